>>> hdl/text_log_row_ring_assert.svh
// Assertion macros shared by the row ring modules.
// Define ASSERT_OFF to compile them away.
`ifndef TEXT_LOG_ROW_RING_ASSERT_SVH
`define TEXT_LOG_ROW_RING_ASSERT_SVH
`ifndef ASSERT_OFF
// Consequent checked in the same cycle as the antecedent.
`define TLR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("row ring assertion failed");
// Consequent checked in the cycle after the antecedent.
`define TLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("row ring assertion failed");
`else
`define TLR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/tlr_pkg.sv
`default_nettype none

package tlr_pkg;

    // Opcodes of an input word.
    localparam logic [2:0] OP_PUT      = 3'd0;
    localparam logic [2:0] OP_READ_REL = 3'd1;
    localparam logic [2:0] OP_READ_ABS = 3'd2;
    localparam logic [2:0] OP_READ_CNT = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;
    localparam logic [2:0] OP_QUERY    = 3'd5;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL      = 8'd0;
    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_FORMFEED = 8'd12;
    localparam logic [7:0] CH_RETURN   = 8'd13;
    localparam logic [7:0] CH_SPACE    = 8'd32;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Row and column fields are sized for the largest ring.
    localparam int PTR_W = 6;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [7:0]       t_char;
    typedef logic [31:0]      t_count;
    typedef logic [2:0]       t_opcode;
    typedef logic [6:0]       t_index;

    typedef enum logic [2:0] {
        CMD_WRITE,
        CMD_INIT,
        CMD_READ,
        CMD_STATUS,
        CMD_QUERY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_ptr      row;
        t_ptr      col;
        t_char     ch;
        t_ptr      fill;
        logic      overlay;
        logic      row_valid;
        t_count    next_counter;
        t_count    row_count;
        t_ptr      top_row;
        t_ptr      bottom_row;
    } t_cmd;

    typedef struct packed {
        t_char  out_char;
        t_ptr   column;
        logic   last;
        logic   status;
        t_count next_counter;
        t_count row_count;
        t_ptr   top_row;
        t_ptr   bottom_row;
    } t_res;

    typedef enum logic {
        FS_IDLE,
        FS_COUNT
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_INIT,
        BS_READ
    } t_back_state;

endpackage

`default_nettype wire

>>> hdl/tlr_if.sv
`default_nettype none

interface tlr_in_if import tlr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_char   character;
    t_index  row_index;
    t_count  counter;

    modport source (output valid, output opcode, output character, output row_index,
                    output counter, input ready);
    modport sink   (input valid, input opcode, input character, input row_index,
                    input counter, output ready);
endinterface

interface tlr_out_if import tlr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_char  out_char;
    t_ptr   column;
    logic   last;
    logic   status;
    t_count next_counter;
    t_count row_count;
    t_ptr   top_row;
    t_ptr   bottom_row;

    modport source (output valid, output out_char, output column, output last,
                    output status, output next_counter, output row_count,
                    output top_row, output bottom_row, input ready);
    modport sink   (input valid, input out_char, input column, input last,
                    input status, input next_counter, input row_count,
                    input top_row, input bottom_row, output ready);
endinterface

`default_nettype wire

>>> hdl/tlr_queue.sv
`default_nettype none
`include "text_log_row_ring_assert.svh"

module tlr_queue import tlr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_fill;

    assign o_full  = (r_fill == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // The front must see the queue full and hold off; the back pops only what is there.
    `TLR_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop)
    `TLR_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

`default_nettype wire

>>> hdl/tlr_front.sv
`default_nettype none

module tlr_front import tlr_pkg::*; #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tlr_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    t_front_state  r_state, n_state;
    logic [RW-1:0] r_cur, n_cur;
    logic [RW-1:0] r_old, n_old;
    logic [CW-1:0] r_cursor, n_cursor;
    t_count        r_count, n_count;
    t_count        r_least, n_least;
    logic [ROWS-1:0] r_valid, n_valid;
    t_count        r_cnt_in, n_cnt_in;
    logic [RW-1:0] r_dist, n_dist;

    logic          accept;
    logic [RW-1:0] cur_inc;
    logic [RW-1:0] old_inc;
    logic          do_scroll;
    logic          new_valid;
    logic [RW:0]   rel_diff;
    logic [RW-1:0] rel_row;
    logic [RW-1:0] rd_row;
    logic          idx_bad;
    t_count        cnt_diff;
    logic          cnt_inside;
    logic [RW:0]   cnt_sum;
    logic [RW-1:0] cnt_row;

    assign i_in.ready = (r_state == FS_IDLE) && !i_full;
    assign accept     = i_in.valid && i_in.ready;

    assign cur_inc = (r_cur == LAST_ROW) ? '0 : r_cur + 1'b1;
    assign old_inc = (r_old == LAST_ROW) ? '0 : r_old + 1'b1;

    // Relative read: current row minus index, modulo the ring size.
    assign rel_diff = {1'b0, r_cur} - {1'b0, i_in.row_index[RW-1:0]};
    assign rel_row  = rel_diff[RW] ? RW'(rel_diff[RW-1:0] + RW'(ROWS)) : rel_diff[RW-1:0];
    assign rd_row   = (i_in.opcode == OP_READ_REL) ? rel_row : i_in.row_index[RW-1:0];
    assign idx_bad  = (i_in.row_index >= 7'(ROWS));

    // Distance of the caller's counter above the oldest stored counter.
    assign cnt_diff   = i_in.counter - r_least;
    assign cnt_inside = (cnt_diff < 32'(ROWS));

    // The oldest row sits one past the current row, so the row is cur + dist + 1.
    assign cnt_sum = {1'b0, r_cur} + {1'b0, r_dist} + (RW+1)'(1);
    assign cnt_row = (cnt_sum >= (RW+1)'(ROWS)) ? RW'(cnt_sum - (RW+1)'(ROWS))
                                                 : cnt_sum[RW-1:0];

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_old     = r_old;
        n_cursor  = r_cursor;
        n_count   = r_count;
        n_least   = r_least;
        n_valid   = r_valid;
        n_cnt_in  = r_cnt_in;
        n_dist    = r_dist;
        do_scroll = 1'b0;
        new_valid = 1'b0;
        o_push    = 1'b0;
        o_cmd            = '0;
        o_cmd.kind       = CMD_WRITE;
        o_cmd.row_count  = r_count;
        o_cmd.top_row    = PTR_W'(r_cur);
        o_cmd.bottom_row = PTR_W'(r_old);

        case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    case (i_in.opcode)
                        OP_PUT: begin
                            case (i_in.character)
                                CH_NUL: begin
                                end
                                CH_NEWLINE: begin
                                    do_scroll = 1'b1;
                                    n_cursor  = '0;
                                end
                                CH_RETURN: begin
                                    n_cursor = '0;
                                end
                                CH_FORMFEED: begin
                                    do_scroll  = 1'b1;
                                    new_valid  = 1'b1;
                                    o_push     = 1'b1;
                                    o_cmd.kind = CMD_INIT;
                                    o_cmd.row  = PTR_W'(cur_inc);
                                    o_cmd.fill = PTR_W'(r_cursor);
                                end
                                default: begin
                                    o_push    = 1'b1;
                                    o_cmd.row = PTR_W'(r_cur);
                                    o_cmd.col = PTR_W'(r_cursor);
                                    o_cmd.ch  = i_in.character;
                                    if (!r_valid[r_cur]) begin
                                        // Fresh row: zero it and drop the byte in.
                                        o_cmd.kind     = CMD_INIT;
                                        o_cmd.overlay  = 1'b1;
                                        n_valid[r_cur] = 1'b1;
                                    end
                                    if (r_cursor == LAST_COL) begin
                                        do_scroll = 1'b1;
                                        n_cursor  = '0;
                                    end else begin
                                        n_cursor = r_cursor + 1'b1;
                                    end
                                end
                            endcase
                        end
                        OP_READ_REL, OP_READ_ABS: begin
                            o_push = 1'b1;
                            if (idx_bad) begin
                                o_cmd.kind = CMD_STATUS;
                            end else begin
                                o_cmd.kind      = CMD_READ;
                                o_cmd.row       = PTR_W'(rd_row);
                                o_cmd.row_valid = r_valid[rd_row];
                            end
                        end
                        OP_READ_CNT: begin
                            n_cnt_in = cnt_inside ? i_in.counter : r_least;
                            n_dist   = cnt_inside ? cnt_diff[RW-1:0] : '0;
                            n_state  = FS_COUNT;
                        end
                        OP_CLEAR: begin
                            n_valid  = '0;
                            n_cursor = '0;
                        end
                        OP_QUERY: begin
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_QUERY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FS_COUNT: begin
                if (!i_full) begin
                    o_push             = 1'b1;
                    o_cmd.kind         = CMD_READ;
                    o_cmd.row          = PTR_W'(cnt_row);
                    o_cmd.row_valid    = r_valid[cnt_row];
                    o_cmd.next_counter = (r_dist == LAST_ROW) ? r_count : r_cnt_in + 32'd1;
                    n_state            = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase

        if (do_scroll) begin
            n_cur            = cur_inc;
            n_old            = old_inc;
            n_count          = r_count + 32'd1;
            n_least          = r_least + 32'd1;
            n_valid[cur_inc] = new_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_cur    <= '0;
            r_old    <= RW'(1);
            r_cursor <= '0;
            r_count  <= '0;
            r_least  <= 32'd0 - 32'(ROWS - 1);
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_old    <= n_old;
            r_cursor <= n_cursor;
            r_count  <= n_count;
            r_least  <= n_least;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt_in <= n_cnt_in;
        r_dist   <= n_dist;
    end

endmodule

`default_nettype wire

>>> hdl/tlr_back.sv
`default_nettype none
`include "text_log_row_ring_assert.svh"

module tlr_back import tlr_pkg::*; #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    tlr_out_if.source  o_out
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    t_back_state   r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_pcol, n_pcol;
    logic          r_pend, n_pend;
    logic          r_oval, n_oval;
    t_res          r_res, n_res;
    t_char         r_mem [DEPTH];
    t_char         r_rdata;

    logic          wen;
    logic          ren;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_char         wdata;
    logic          out_free;

    assign out_free = !r_oval || o_out.ready;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_col   = r_col;
        n_pcol  = r_pcol;
        n_pend  = r_pend;
        n_oval  = r_oval && !o_out.ready;
        n_res   = r_res;
        o_pop   = 1'b0;
        wen     = 1'b0;
        ren     = 1'b0;
        waddr   = {r_cmd.row[RW-1:0], r_col};
        raddr   = {r_cmd.row[RW-1:0], r_col};
        wdata   = CH_NUL;

        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.kind)
                        CMD_WRITE: begin
                            o_pop = 1'b1;
                            wen   = 1'b1;
                            waddr = {i_cmd.row[RW-1:0], i_cmd.col[CW-1:0]};
                            wdata = i_cmd.ch;
                        end
                        CMD_INIT: begin
                            o_pop   = 1'b1;
                            n_cmd   = i_cmd;
                            n_col   = '0;
                            n_state = BS_INIT;
                        end
                        CMD_READ: begin
                            o_pop   = 1'b1;
                            n_cmd   = i_cmd;
                            n_col   = '0;
                            n_pend  = 1'b0;
                            n_state = BS_READ;
                        end
                        CMD_STATUS, CMD_QUERY: begin
                            if (out_free) begin
                                o_pop              = 1'b1;
                                n_oval             = 1'b1;
                                n_res.out_char     = CH_NUL;
                                n_res.column       = '0;
                                n_res.last         = 1'b1;
                                n_res.status       = (i_cmd.kind == CMD_STATUS) ? STATUS_RANGE
                                                                                : STATUS_OK;
                                n_res.next_counter = '0;
                                n_res.row_count    = i_cmd.row_count;
                                n_res.top_row      = i_cmd.top_row;
                                n_res.bottom_row   = i_cmd.bottom_row;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_INIT: begin
                // Spaces below the fill mark, the overlay byte at its column, zero elsewhere.
                wen = 1'b1;
                if (r_col < r_cmd.fill[CW-1:0]) begin
                    wdata = CH_SPACE;
                end else if (r_cmd.overlay && (r_col == r_cmd.col[CW-1:0])) begin
                    wdata = r_cmd.ch;
                end else begin
                    wdata = CH_NUL;
                end
                if (r_col == LAST_COL) begin
                    n_state = BS_IDLE;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            BS_READ: begin
                if (r_pend) begin
                    n_pend             = 1'b0;
                    n_oval             = 1'b1;
                    n_res.out_char     = r_cmd.row_valid ? r_rdata : CH_NUL;
                    n_res.column       = PTR_W'(r_pcol);
                    n_res.last         = (r_pcol == LAST_COL);
                    n_res.status       = STATUS_OK;
                    n_res.next_counter = r_cmd.next_counter;
                    n_res.row_count    = r_cmd.row_count;
                    n_res.top_row      = r_cmd.top_row;
                    n_res.bottom_row   = r_cmd.bottom_row;
                    if (r_pcol == LAST_COL) begin
                        n_state = BS_IDLE;
                    end
                end else if (out_free) begin
                    ren    = 1'b1;
                    n_pend = 1'b1;
                    n_pcol = r_col;
                    n_col  = r_col + 1'b1;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        if (ren) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_pend  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_col  <= n_col;
        r_pcol <= n_pcol;
        r_res  <= n_res;
    end

    assign o_out.valid        = r_oval;
    assign o_out.out_char     = r_res.out_char;
    assign o_out.column       = r_res.column;
    assign o_out.last         = r_res.last;
    assign o_out.status       = r_res.status;
    assign o_out.next_counter = r_res.next_counter;
    assign o_out.row_count    = r_res.row_count;
    assign o_out.top_row      = r_res.top_row;
    assign o_out.bottom_row   = r_res.bottom_row;

    // A read is only issued when the output register will be empty on its return.
    `TLR_ASSERT_SAME(a_read_lands_free, i_clk, i_rst_n, r_pend, !r_oval)
    `TLR_ASSERT_NEXT(a_init_sweep_ends, i_clk, i_rst_n,
                     (r_state == BS_INIT) && (r_col == LAST_COL), r_state == BS_IDLE)

endmodule

`default_nettype wire

>>> hdl/text_log_row_ring.sv
`default_nettype none

// Circular scrollback of ROWS text rows, COLS bytes each. Words enter on i_in and are
// decoded by a front end that owns the cursor, the row pointers and the 32-bit row
// counter, then pass as commands through a two-entry queue to a back end that owns the
// text memory and the result register. The front end takes one word per cycle while
// the queue has room and no read by counter is resolving its counter window; such a
// read holds off the next word until its command is queued. In the back end a newline
// or carriage return costs nothing, and a form feed or the first byte written into a
// fresh row costs a sweep over that row's memory. A row read gives COLS words, each
// through a memory read and then the result register, and the next read waits until
// the last word is in that register; any stall on o_out holds it further. Each row
// carries a valid bit that reset and the clear opcode drop at once, so a scrolled or
// cleared row reads as zeros without touching memory and there is no clearing pass
// after reset.
module text_log_row_ring import tlr_pkg::*; #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlr_in_if.sink    i_in,
    tlr_out_if.source o_out
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Front end: decodes words, tracks cursor and row pointers, issues memory commands.
    tlr_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Command queue that lets the front end keep taking words during a long row sweep.
    tlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    // Back end: text memory, row sweeps and the registered result word.
    tlr_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
module tb_top;
    import tlr_pkg::*;

    // Ring geometry of the instance under test.
    localparam int ROWS = 32;
    localparam int COLS = 64;

    // Words counted toward each random phase. Words with an unused opcode are extra.
    localparam int PHASE_ITEMS = 130;

    // Cycles with no word moving on either side before the run is declared hung. The
    // limit is meant to lie well above the slowest gap that a row read under the heaviest
    // receiver stall or a form feed sweep can cause.
    localparam int HANG_LIMIT = 4000;

    // Settling time after the last expected word, longer than a full row read.
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        t_opcode op;
        t_char   ch;
        t_index  idx;
        t_count  cnt;
    } t_in_word;

    // One row of the directed script. When fixed_result is set, the single word that
    // the block must return is written out by hand instead of coming from the model.
    typedef struct {
        t_in_word w;
        bit       fixed_result;
        t_res     want;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    tlr_in_if  in_if ();
    tlr_out_if out_if ();

    text_log_row_ring #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Free running clock, period 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the ring: text bytes, row pointers, cursor and scroll counter.
    t_char       shadow_text [ROWS*COLS];
    t_ptr        shadow_top;
    t_ptr        shadow_oldest;
    int unsigned shadow_cursor;
    t_count      shadow_scrolls;

    // Words produced by the last input word, and the words still owed by the block.
    t_res row_words [$];
    t_res due_words [$];

    // Directed script, walked in order before the random part.
    t_script_row script_rows [$];

    // Hand-written expectation attached to the word currently on the input side.
    bit   hold_fixed;
    t_res hold_want;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int hang_cycles;

    function automatic void shadow_reset();
        foreach (shadow_text[i]) shadow_text[i] = CH_NUL;
        shadow_top     = '0;
        shadow_oldest  = t_ptr'(1 % ROWS);
        shadow_cursor  = 0;
        shadow_scrolls = '0;
    endfunction

    // A scroll moves to the next physical row, wipes it and bumps the row counter.
    // The oldest row is always the one just after the current row.
    function automatic void shadow_scroll();
        shadow_top     = t_ptr'((int'(shadow_top) + 1) % ROWS);
        shadow_oldest  = t_ptr'((int'(shadow_top) + 1) % ROWS);
        shadow_scrolls = shadow_scrolls + 1;
        for (int c = 0; c < COLS; c++) shadow_text[int'(shadow_top)*COLS + c] = CH_NUL;
    endfunction

    // Every result word carries the pointers and the counter as they stand after the
    // input word that caused it.
    function automatic t_res ring_result(t_char ch, t_ptr col, logic last, logic status,
                                         t_count next_cnt);
        t_res r;
        r.out_char     = ch;
        r.column       = col;
        r.last         = last;
        r.status       = status;
        r.next_counter = next_cnt;
        r.row_count    = shadow_scrolls;
        r.top_row      = shadow_top;
        r.bottom_row   = shadow_oldest;
        return r;
    endfunction

    // A row read returns every column in order and marks the last one.
    function automatic void emit_row(int row, t_count next_cnt);
        for (int c = 0; c < COLS; c++) begin
            row_words.push_back(ring_result(shadow_text[row*COLS + c], t_ptr'(c),
                                            c == COLS - 1, STATUS_OK, next_cnt));
        end
    endfunction

    // The stored window of row counters is [scrolls - ROWS + 1, scrolls], taken
    // circularly, so it wraps through zero while fewer than ROWS - 1 scrolls have happened.
    function automatic bit outside_window(t_count c);
        t_count least;
        least = shadow_scrolls - t_count'(ROWS - 1);
        if (shadow_scrolls > least) return (c < least) || (c > shadow_scrolls);
        return (c < least) && (c > shadow_scrolls);
    endfunction

    function automatic void shadow_put(t_char ch);
        case (ch)
            CH_NUL: ;
            CH_NEWLINE: begin
                shadow_scroll();
                shadow_cursor = 0;
            end
            CH_RETURN: begin
                shadow_cursor = 0;
            end
            CH_FORMFEED: begin
                // The new row is padded with spaces up to the cursor, which is kept.
                shadow_scroll();
                for (int c = 0; c < int'(shadow_cursor) && c < COLS; c++)
                    shadow_text[int'(shadow_top)*COLS + c] = CH_SPACE;
            end
            default: begin
                if (shadow_cursor < COLS)
                    shadow_text[int'(shadow_top)*COLS + int'(shadow_cursor)] = ch;
                shadow_cursor++;
                if (shadow_cursor >= COLS) begin
                    shadow_scroll();
                    shadow_cursor = 0;
                end
            end
        endcase
    endfunction

    // Applies one accepted input word to the shadow ring and leaves the result words
    // it causes in row_words.
    function automatic void predict_ring_words(t_in_word w);
        int     row;
        int     back;
        t_count c;
        row_words.delete();
        case (w.op)
            OP_PUT: shadow_put(w.ch);
            OP_READ_REL, OP_READ_ABS: begin
                if (int'(w.idx) >= ROWS) begin
                    row_words.push_back(ring_result(CH_NUL, '0, 1'b1, STATUS_RANGE, '0));
                end else begin
                    row = int'(w.idx);
                    if (w.op == OP_READ_REL) row = (int'(shadow_top) + ROWS - row) % ROWS;
                    emit_row(row, '0);
                end
            end
            OP_READ_CNT: begin
                // A counter that fell out of the window is pulled up to the oldest row.
                c = w.cnt;
                if (outside_window(c)) c = shadow_scrolls - t_count'(ROWS - 1);
                back = int'((shadow_scrolls - c) % t_count'(ROWS));
                row  = (int'(shadow_top) + ROWS - back) % ROWS;
                c    = c + 1;
                if (outside_window(c)) c = shadow_scrolls;
                emit_row(row, c);
            end
            OP_CLEAR: begin
                // Pointers and counter survive a clear; text and cursor do not.
                shadow_cursor = 0;
                foreach (shadow_text[i]) shadow_text[i] = CH_NUL;
            end
            OP_QUERY: row_words.push_back(ring_result(CH_NUL, '0, 1'b1, STATUS_OK, '0));
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(string what, t_count got, t_count want);
        $display("mismatch: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic check_word(t_res got);
        t_res want;
        if (due_words.size() == 0) begin
            flag_mismatch("output word with nothing expected", t_count'(got.out_char), '0);
        end else begin
            want = due_words.pop_front();
            if (got.out_char !== want.out_char)
                flag_mismatch("out_char", t_count'(got.out_char), t_count'(want.out_char));
            if (got.column !== want.column)
                flag_mismatch("column", t_count'(got.column), t_count'(want.column));
            if (got.last !== want.last)
                flag_mismatch("last", t_count'(got.last), t_count'(want.last));
            if (got.status !== want.status)
                flag_mismatch("status", t_count'(got.status), t_count'(want.status));
            if (got.next_counter !== want.next_counter)
                flag_mismatch("next_counter", got.next_counter, want.next_counter);
            if (got.row_count !== want.row_count)
                flag_mismatch("row_count", got.row_count, want.row_count);
            if (got.top_row !== want.top_row)
                flag_mismatch("top_row", t_count'(got.top_row), t_count'(want.top_row));
            if (got.bottom_row !== want.bottom_row)
                flag_mismatch("bottom_row", t_count'(got.bottom_row),
                              t_count'(want.bottom_row));
        end
    endtask

    // Both sides are watched at the rising edge. An accepted input word is run through
    // the shadow ring first, so its results are queued before any of them can appear.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                predict_ring_words('{op: in_if.opcode, ch: in_if.character,
                                     idx: in_if.row_index, cnt: in_if.counter});
                if (hold_fixed) due_words.push_back(hold_want);
                else foreach (row_words[i]) due_words.push_back(row_words[i]);
            end
            if (out_if.valid && out_if.ready) begin
                check_word('{out_char: out_if.out_char, column: out_if.column,
                             last: out_if.last, status: out_if.status,
                             next_counter: out_if.next_counter,
                             row_count: out_if.row_count, top_row: out_if.top_row,
                             bottom_row: out_if.bottom_row});
            end
        end
    end

    // Hang detector: any accepted word on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            hang_cycles <= 0;
        end else begin
            hang_cycles <= hang_cycles + 1;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver back-pressure, rerolled every cycle.
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Presents one word, with random sender gaps ahead of it, and returns at the falling
    // edge after it was taken. Valid stays high when the next word follows without a gap.
    task automatic send_word(t_in_word w, bit fixed = 1'b0, t_res want = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.opcode    <= w.op;
        in_if.character <= w.ch;
        in_if.row_index <= w.idx;
        in_if.counter   <= w.cnt;
        hold_fixed      <= fixed;
        hold_want       <= want;
        @(posedge i_clk);
        while (!(in_if.valid && in_if.ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Fields that the opcode does not use are filled with noise.
    function automatic t_in_word noise_word(t_opcode op);
        t_in_word w;
        w.op  = op;
        w.ch  = t_char'($urandom);
        w.idx = t_index'($urandom);
        w.cnt = $urandom;
        return w;
    endfunction

    // Mostly printable text, sometimes any nonzero byte (controls included).
    function automatic t_char text_byte();
        if ($urandom_range(9) < 8) return t_char'($urandom_range(33, 126));
        return t_char'($urandom_range(1, 255));
    endfunction

    // Row index for a read: mostly inside the ring, sometimes anywhere in the field.
    function automatic t_index read_index();
        if ($urandom_range(4) != 0) return t_index'($urandom_range(0, ROWS - 1));
        return t_index'($urandom_range(0, 127));
    endfunction

    // Counter for a read by counter: the window edges, one step past each edge,
    // somewhere inside the window, or anything at all.
    function automatic t_count read_counter();
        case ($urandom_range(5))
            0: return shadow_scrolls;
            1: return shadow_scrolls - t_count'(ROWS - 1);
            2: return shadow_scrolls - t_count'(ROWS);
            3: return shadow_scrolls + 1;
            4: return shadow_scrolls - t_count'($urandom_range(0, ROWS - 1));
            default: return $urandom;
        endcase
    endfunction

    // Status-only word for the state right after reset.
    function automatic t_res reset_status_word(logic status);
        return '{out_char: CH_NUL, column: '0, last: 1'b1, status: status,
                 next_counter: '0, row_count: '0, top_row: '0, bottom_row: t_ptr'(1)};
    endfunction

    task automatic add_row(t_opcode op, t_char ch, t_index idx, t_count cnt,
                           bit fixed = 1'b0, t_res want = '0);
        script_rows.push_back('{w: '{op: op, ch: ch, idx: idx, cnt: cnt},
                                fixed_result: fixed, want: want});
    endtask

    initial begin
        t_in_word w;
        int       sent;
        int       pick;
        int       len;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.opcode    = OP_PUT;
        in_if.character = CH_NUL;
        in_if.row_index = '0;
        in_if.counter   = '0;
        out_if.ready    = 1'b0;
        hold_fixed      = 1'b0;
        hold_want       = '0;
        mismatches      = 0;
        hang_cycles     = 0;
        send_idle_pct   = 31;
        recv_idle_pct   = 84;
        shadow_reset();

        // Directed script. The fixed rows among the first check the reset state and the range
        // errors by hand; every other row is checked against the shadow ring.
        add_row(OP_QUERY, CH_NUL, '0, '0, 1'b1, reset_status_word(STATUS_OK));
        add_row(OP_READ_ABS, CH_NUL, '0, '0);
        add_row(OP_READ_REL, CH_NUL, t_index'(ROWS), '0, 1'b1,
                reset_status_word(STATUS_RANGE));
        add_row(OP_READ_ABS, 8'hff, 7'd127, 32'hffff_ffff, 1'b1,
                reset_status_word(STATUS_RANGE));
        add_row(OP_PUT, CH_NUL, '0, '0);
        add_row(OP_PUT, 8'd65, '0, '0);
        add_row(OP_PUT, 8'd255, '0, '0);
        add_row(OP_PUT, 8'd1, '0, '0);
        add_row(OP_PUT, CH_RETURN, '0, '0);
        add_row(OP_PUT, 8'd66, '0, '0);
        add_row(OP_PUT, CH_FORMFEED, '0, '0);
        add_row(OP_PUT, 8'd67, '0, '0);
        add_row(OP_PUT, CH_NEWLINE, '0, '0);
        add_row(3'd6, 8'd88, 7'd3, 32'd1);
        add_row(3'd7, 8'd89, 7'd4, 32'd2);
        add_row(OP_READ_REL, CH_NUL, '0, '0);
        add_row(OP_READ_REL, CH_NUL, 7'd1, '0);
        add_row(OP_READ_REL, CH_NUL, t_index'(ROWS - 1), '0);
        add_row(OP_READ_ABS, CH_NUL, t_index'(ROWS - 1), '0);
        add_row(OP_READ_CNT, CH_NUL, '0, '0);
        add_row(OP_READ_CNT, CH_NUL, '0, 32'hffff_ffff);
        add_row(OP_READ_CNT, CH_NUL, '0, 32'd2);
        add_row(OP_CLEAR, CH_NUL, '0, '0);
        add_row(OP_READ_ABS, CH_NUL, 7'd1, '0);
        add_row(OP_QUERY, CH_NUL, '0, '0);

        // Reset is released on a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script_rows[i])
            send_word(script_rows[i].w, script_rows[i].fixed_result, script_rows[i].want);

        // Random part in three phases: slow receiver, then slow sender, then no gaps.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                w = noise_word(OP_PUT);
                if (pick < 20) begin
                    // A line of text, long enough at times to wrap a full row, then a
                    // line ending of some kind, or none.
                    len = $urandom_range(1, 70);
                    // Near the end of a phase the line is cut to what the phase has left.
                    if (len > PHASE_ITEMS - sent - 1)
                        len = (PHASE_ITEMS - sent > 1) ? PHASE_ITEMS - sent - 1 : 1;
                    repeat (len) begin
                        w = noise_word(OP_PUT);
                        w.ch = text_byte();
                        send_word(w);
                    end
                    case ($urandom_range(3))
                        0: w.ch = CH_NEWLINE;
                        1: w.ch = CH_RETURN;
                        2: w.ch = CH_FORMFEED;
                        default: w.ch = text_byte();
                    endcase
                    send_word(w);
                    sent += len + 1;
                end else if (pick < 45) begin
                    case ($urandom_range(7))
                        0: w.ch = CH_NEWLINE;
                        1: w.ch = CH_RETURN;
                        2: w.ch = CH_FORMFEED;
                        3: w.ch = CH_NUL;
                        default: w.ch = t_char'($urandom_range(1, 255));
                    endcase
                    send_word(w);
                    sent++;
                end else if (pick < 57) begin
                    w = noise_word(OP_READ_REL);
                    w.idx = read_index();
                    send_word(w);
                    sent++;
                end else if (pick < 67) begin
                    w = noise_word(OP_READ_ABS);
                    w.idx = read_index();
                    send_word(w);
                    sent++;
                end else if (pick < 82) begin
                    w = noise_word(OP_READ_CNT);
                    w.cnt = read_counter();
                    send_word(w);
                    sent++;
                end else if (pick < 85) begin
                    send_word(noise_word(OP_CLEAR));
                    sent++;
                end else if (pick < 93) begin
                    send_word(noise_word(OP_QUERY));
                    sent++;
                end else begin
                    // Unused opcodes must be swallowed without a result.
                    send_word(noise_word(t_opcode'($urandom_range(6, 7))));
                end
            end
        end
        in_if.valid <= 1'b0;

        // Wait for every owed word, then give the block time to show anything extra.
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/tlr_pkg.sv
hdl/tlr_if.sv
hdl/tlr_queue.sv
hdl/tlr_front.sv
hdl/tlr_back.sv
hdl/text_log_row_ring.sv
bench/tb_top.sv
